// File: hw/rtl/hrp_pkg.sv
// Shared types, constants and helper functions for the HTTP response header parser.
package hrp_pkg;

  // Widest match string, in bits; shorter strings sit right-aligned in this width.
  localparam int unsigned StrW = 23 * 8;

  localparam logic [4:0] MultiLen     = 5'd23;
  localparam logic [4:0] ClenLen      = 5'd15;
  localparam logic [4:0] TencLen      = 5'd18;
  localparam logic [4:0] HttpLen      = 5'd4;
  localparam logic [4:0] ChunkLen     = 5'd7;
  localparam logic [4:0] ClenDigitPos = 5'd16;
  localparam logic [4:0] PosMax       = 5'd31;
  localparam logic [2:0] ChunkDone    = 3'd7;

  // Case-folded prefixes are held in lower case.
  localparam logic [StrW-1:0] MultiStr = "content-type: multipart";
  localparam logic [StrW-1:0] ClenStr  = "content-length:";
  localparam logic [StrW-1:0] TencStr  = "transfer-encoding:";
  localparam logic [StrW-1:0] HttpStr  = "HTTP";
  localparam logic [StrW-1:0] ChunkStr = "chunked";

  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0b;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;

  // Prefix flag bit positions.
  localparam int unsigned FlagMulti = 0;
  localparam int unsigned FlagClen  = 1;
  localparam int unsigned FlagTenc  = 2;
  localparam int unsigned FlagHttp  = 3;

  typedef enum logic [1:0] {
    ModeNone     = 2'd0,
    ModeLength   = 2'd1,
    ModeChunked  = 2'd2,
    ModeBoundary = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ScanToken   = 4'b0001,
    ScanWhite   = 4'b0010,
    ScanDigits  = 4'b0100,
    ScanStopped = 4'b1000
  } scan_e;

  typedef struct packed {
    logic [4:0]  line_pos;
    logic        first_line;
    logic [3:0]  pfx_flags;
    logic        has_content;
    logic [2:0]  chunk_st;
    scan_e       scan_phase;
    logic [15:0] code_acc;
    logic        code_found;
    logic        len_over;
    logic [63:0] len_acc;
    logic        len_seen;
    logic [63:0] len_reg;
    mode_e       mode;
    logic        hdr_done;
    logic [31:0] byte_cnt;
  } state_t;

  typedef struct packed {
    logic        header_done;
    logic        code_valid;
    logic [15:0] status_code;
    mode_e       transfer_mode;
    logic [63:0] body_length;
    logic [31:0] bytes_consumed;
  } result_t;

  localparam state_t StateReset = '{
    line_pos:    5'd0,
    first_line:  1'b1,
    pfx_flags:   4'hf,
    has_content: 1'b0,
    chunk_st:    3'd0,
    scan_phase:  ScanToken,
    code_acc:    16'd0,
    code_found:  1'b0,
    len_over:    1'b0,
    len_acc:     64'd0,
    len_seen:    1'b0,
    len_reg:     64'd0,
    mode:        ModeNone,
    hdr_done:    1'b0,
    byte_cnt:    32'd0
  };

  // Character at position pos of a right-aligned string of length len (pos < len).
  function automatic logic [7:0] char_at(logic [StrW-1:0] s, logic [4:0] len,
                                         logic [4:0] pos);
    logic [7:0]      amt;
    logic [StrW-1:0] sh;
    amt = {len - 5'd1 - pos, 3'b000};
    sh  = s >> amt;
    return sh[7:0];
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= ChUpA && c <= ChUpZ) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_white(logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChCr || c == ChVt || c == ChFf;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

endpackage

// File: hw/rtl/hrp_step.sv
// Next-state and result logic for one received byte of the header parser.
module hrp_step (
  input  hrp_pkg::state_t  state_i,
  input  logic [7:0]       data_byte_i,
  input  logic             restart_i,
  output hrp_pkg::state_t  state_o,
  output logic             res_valid_o,
  output hrp_pkg::result_t res_o
);

  hrp_pkg::state_t st;
  hrp_pkg::state_t nxt;
  logic [7:0]  lc;
  logic [3:0]  dig;
  logic        white;
  logic        digit;
  logic        m_multi;
  logic        m_clen;
  logic        m_tenc;
  logic        m_http;
  logic [3:0]  pfx_new;
  logic [19:0] code_prod;
  logic [15:0] code_sat;
  logic [67:0] len_prod;
  logic [63:0] len_sat;

  assign st    = restart_i ? hrp_pkg::StateReset : state_i;
  assign lc    = hrp_pkg::to_lower(data_byte_i);
  assign dig   = data_byte_i[3:0];
  assign white = hrp_pkg::is_white(data_byte_i);
  assign digit = hrp_pkg::is_digit(data_byte_i);

  // Compare against each prefix; past its end a prefix no longer changes.
  assign m_multi = (st.line_pos >= hrp_pkg::MultiLen) ||
      (lc == hrp_pkg::char_at(hrp_pkg::MultiStr, hrp_pkg::MultiLen, st.line_pos));
  assign m_clen = (st.line_pos >= hrp_pkg::ClenLen) ||
      (lc == hrp_pkg::char_at(hrp_pkg::ClenStr, hrp_pkg::ClenLen, st.line_pos));
  assign m_tenc = (st.line_pos >= hrp_pkg::TencLen) ||
      (lc == hrp_pkg::char_at(hrp_pkg::TencStr, hrp_pkg::TencLen, st.line_pos));
  assign m_http = (st.line_pos >= hrp_pkg::HttpLen) ||
      (data_byte_i == hrp_pkg::char_at(hrp_pkg::HttpStr, hrp_pkg::HttpLen, st.line_pos));
  assign pfx_new = st.pfx_flags & {m_http, m_tenc, m_clen, m_multi};

  // Times ten plus digit as shifts and adds, then saturate.
  assign code_prod = ({4'b0, st.code_acc} << 3) + ({4'b0, st.code_acc} << 1) + {16'b0, dig};
  assign code_sat  = (|code_prod[19:16]) ? 16'hffff : code_prod[15:0];
  assign len_prod  = ({4'b0, st.len_acc} << 3) + ({4'b0, st.len_acc} << 1) + {64'b0, dig};
  assign len_sat   = (|len_prod[67:64]) ? '1 : len_prod[63:0];

  always_comb begin
    nxt         = st;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (!st.hdr_done) begin
      if (st.byte_cnt != '1) begin
        nxt.byte_cnt = st.byte_cnt + 32'd1;
      end
      if (data_byte_i != hrp_pkg::ChLf) begin
        if (data_byte_i != hrp_pkg::ChCr) begin
          nxt.has_content = 1'b1;
        end
        nxt.pfx_flags = pfx_new;

        if (st.chunk_st != hrp_pkg::ChunkDone) begin
          if (data_byte_i == hrp_pkg::char_at(hrp_pkg::ChunkStr, hrp_pkg::ChunkLen,
                                              {2'b00, st.chunk_st})) begin
            nxt.chunk_st = st.chunk_st + 3'd1;
          end else if (data_byte_i == hrp_pkg::char_at(hrp_pkg::ChunkStr, hrp_pkg::ChunkLen,
                                                       5'd0)) begin
            nxt.chunk_st = 3'd1;
          end else begin
            nxt.chunk_st = 3'd0;
          end
        end

        if (st.first_line) begin
          unique case (st.scan_phase)
            hrp_pkg::ScanToken: begin
              if (white) nxt.scan_phase = hrp_pkg::ScanWhite;
            end
            hrp_pkg::ScanWhite: begin
              if (!white) begin
                nxt.scan_phase = hrp_pkg::ScanStopped;
                if (digit && pfx_new[hrp_pkg::FlagHttp]) begin
                  nxt.scan_phase = hrp_pkg::ScanDigits;
                  nxt.code_found = 1'b1;
                  nxt.code_acc   = {12'b0, dig};
                end
              end
            end
            hrp_pkg::ScanDigits: begin
              if (digit && pfx_new[hrp_pkg::FlagHttp]) begin
                nxt.code_acc = code_sat;
              end else begin
                nxt.scan_phase = hrp_pkg::ScanStopped;
              end
            end
            hrp_pkg::ScanStopped: begin
            end
            default: begin
              nxt.scan_phase = hrp_pkg::ScanStopped;
            end
          endcase
        end

        if (st.line_pos >= hrp_pkg::ClenDigitPos && pfx_new[hrp_pkg::FlagClen] &&
            !st.len_over) begin
          if (digit) begin
            nxt.len_acc  = len_sat;
            nxt.len_seen = 1'b1;
          end else begin
            nxt.len_over = 1'b1;
          end
        end

        if (st.line_pos != hrp_pkg::PosMax) begin
          nxt.line_pos = st.line_pos + 5'd1;
        end
      end else begin
        if (!st.has_content) begin
          nxt.hdr_done = 1'b1;
        end else begin
          priority if (st.pfx_flags[hrp_pkg::FlagMulti] &&
                       st.line_pos >= hrp_pkg::MultiLen) begin
            nxt.mode = hrp_pkg::ModeBoundary;
          end else if (st.pfx_flags[hrp_pkg::FlagClen] &&
                       st.line_pos >= hrp_pkg::ClenLen) begin
            if (st.len_seen) nxt.len_reg = st.len_acc;
            nxt.mode = hrp_pkg::ModeLength;
          end else if (st.pfx_flags[hrp_pkg::FlagTenc] &&
                       st.line_pos >= hrp_pkg::TencLen &&
                       st.chunk_st == hrp_pkg::ChunkDone) begin
            nxt.len_reg = '0;
            nxt.mode    = hrp_pkg::ModeChunked;
          end else begin
          end
        end
        // Start a fresh line.
        nxt.first_line  = 1'b0;
        nxt.line_pos    = '0;
        nxt.pfx_flags   = 4'hf;
        nxt.has_content = 1'b0;
        nxt.chunk_st    = '0;
        nxt.len_over    = 1'b0;
        nxt.len_acc     = '0;
        nxt.len_seen    = 1'b0;

        res_valid_o          = 1'b1;
        res_o.header_done    = !st.has_content;
        res_o.code_valid     = nxt.code_found;
        res_o.status_code    = nxt.code_found ? nxt.code_acc : 16'd0;
        res_o.transfer_mode  = nxt.mode;
        res_o.body_length    = nxt.len_reg;
        res_o.bytes_consumed = nxt.byte_cnt;
      end
    end
  end

  assign state_o = nxt;

endmodule

// File: hw/rtl/http_response_header_parser_unit.sv
// Top level of the HTTP response header parser: handshakes, state and result registers.
//
// The parser takes one response byte per transaction and cuts the stream into
// LF-terminated lines. From the first line it reads the decimal status code after
// the version token; on later lines it recognizes Content-Type multipart,
// Content-Length (value read from offset 16) and Transfer-Encoding chunked,
// matching the prefixes case-insensitively. Each completed line yields one result
// transaction carrying the running status code, transfer mode, body length and
// header byte count; other bytes yield none. The empty line ends the header, after
// which bytes are dropped until one arrives with restart_i set. Throughput is one
// byte per clock while the input is not stalled: a byte sits in an input register
// while the per-byte logic (prefix compares and a multiply-by-ten built from shifts
// and adds) updates the parse state and loads the result register, so out_valid_o
// rises once a line's LF has passed through the input register and the result register.
// The input stalls only when the byte in the input register completes a line while
// the result register still holds a result that the downstream side has not taken.
module http_response_header_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        header_done_o,
  output logic        code_valid_o,
  output logic [15:0] status_code_o,
  output logic [1:0]  transfer_mode_o,
  output logic [63:0] body_length_o,
  output logic [31:0] bytes_consumed_o
);

  // Input register.
  logic       s1_valid_q;
  logic       s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_restart_q;

  // Parse state.
  hrp_pkg::state_t state_q;
  hrp_pkg::state_t state_d;

  // Result register.
  logic             out_valid_q;
  logic             out_valid_d;
  hrp_pkg::result_t out_res_q;

  logic             step_res_valid;
  hrp_pkg::result_t step_res;
  logic             out_free;
  logic             s1_go;
  logic             in_accept;

  hrp_step u_step (
    .state_i     (state_q),
    .data_byte_i (s1_byte_q),
    .restart_i   (s1_restart_q),
    .state_o     (state_d),
    .res_valid_o (step_res_valid),
    .res_o       (step_res)
  );

  // The result slot is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || !out_stall_i;
  // Advance the byte unless it completes a line and the slot is occupied.
  assign s1_go      = s1_valid_q && (!step_res_valid || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_go && step_res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= hrp_pkg::StateReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_go) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers: hold while not loading.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q    <= data_byte_i;
      s1_restart_q <= restart_i;
    end
    if (s1_go && step_res_valid) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign header_done_o    = out_res_q.header_done;
  assign code_valid_o     = out_res_q.code_valid;
  assign status_code_o    = out_res_q.status_code;
  assign transfer_mode_o  = out_res_q.transfer_mode;
  assign body_length_o    = out_res_q.body_length;
  assign bytes_consumed_o = out_res_q.bytes_consumed;

`ifndef SYNTHESIS
  // A new result never overwrites one still waiting downstream.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && step_res_valid |-> out_free)
    else $error("result register overwritten while stalled");

  // Without a status code the reported code is zero.
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !code_valid_o |-> status_code_o == 16'd0)
    else $error("status code nonzero without code_valid");

  // Chunked mode always comes with a cleared length.
  a_chunked_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && transfer_mode_o == hrp_pkg::ModeChunked |-> body_length_o == 64'd0)
    else $error("chunked mode with nonzero body length");

  // A header byte taken without restart leaves a nonzero byte count.
  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && !s1_restart_q && !state_q.hdr_done |=> state_q.byte_cnt != 32'd0)
    else $error("byte counter did not advance");
`endif

endmodule
